// File: design/gzh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzh_pkg
// Shared types and constants of the gzip member header parser.
// ----------------------------------------------------------------------------
package gzh_pkg;

    // longest name or comment, in bytes, before it is cut off
    localparam int MAX_STRING = 1024;
    localparam logic [16:0] STR_LIMIT = 17'(MAX_STRING);

    // fixed header bytes
    localparam logic [7:0] GZ_ID1 = 8'h1f;
    localparam logic [7:0] GZ_ID2 = 8'h8b;
    localparam logic [7:0] GZ_CM_DEFLATE = 8'h08;

    // flag bit positions
    localparam int FLG_FHCRC    = 1;
    localparam int FLG_FEXTRA   = 2;
    localparam int FLG_FNAME    = 3;
    localparam int FLG_FCOMMENT = 4;

    // depth of the result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // result word kinds
    typedef enum logic [2:0] {
        KIND_EXTRA   = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_COMMENT = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_BAD     = 3'd4,
        KIND_PAYLOAD = 3'd5
    } kind_t;

    // parse phases
    typedef enum logic [9:0] {
        PH_FIXED   = 10'b00_0000_0001,
        PH_XLEN_LO = 10'b00_0000_0010,
        PH_XLEN_HI = 10'b00_0000_0100,
        PH_EXTRA   = 10'b00_0000_1000,
        PH_NAME    = 10'b00_0001_0000,
        PH_COMMENT = 10'b00_0010_0000,
        PH_CRC_LO  = 10'b00_0100_0000,
        PH_CRC_HI  = 10'b00_1000_0000,
        PH_PAYLOAD = 10'b01_0000_0000,
        PH_ERROR   = 10'b10_0000_0000
    } phase_t;

    // optional sections in stream order
    typedef enum logic [1:0] {
        SEC_XLEN    = 2'd0,
        SEC_NAME    = 2'd1,
        SEC_COMMENT = 2'd2,
        SEC_CRC     = 2'd3
    } sect_t;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  header_flags;
        logic [31:0] mod_time;
        logic [15:0] header_crc;
        logic        last_of_run;
    } result_t;

    // words produced for one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    word0;
        result_t    word1;
    } push_t;

endpackage
`default_nettype wire

// File: design/gzh_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzh_if
// Valid/ready channels of the parser: raw stream bytes in, result words out.
// ----------------------------------------------------------------------------
interface gzh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       first_byte;

    modport source (output valid, output stream_byte, output first_byte, input ready);
    modport sink   (input valid, input stream_byte, input first_byte, output ready);
endinterface

interface gzh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  header_flags;
    logic [31:0] mod_time;
    logic [15:0] header_crc;
    logic        last_of_run;

    modport source (output valid, output kind, output data_byte, output header_flags,
                    output mod_time, output header_crc, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input header_flags,
                    input mod_time, input header_crc, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

// File: design/gzh_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzh_parser
// Header state machine: one stream byte per accept, up to two result words.
// ----------------------------------------------------------------------------
module gzh_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     stream_byte,
    input  wire logic           first_byte,
    output gzh_pkg::push_t      push
);

    gzh_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     count_reg, count_next;
    logic [7:0]      flag_reg, flag_next;
    logic            magic_reg, magic_next;
    logic [31:0]     mtime_reg, mtime_next;
    logic [15:0]     xlen_reg, xlen_next;
    logic [15:0]     crc_reg, crc_next;

    gzh_pkg::kind_t  byte_kind;
    logic            emit_byte;
    logic            emit_done;
    logic            emit_bad;
    logic [16:0]     count_inc;
    logic [15:0]     xlen_full;
    gzh_pkg::result_t byte_word;
    gzh_pkg::result_t end_word;

    // first optional section at or after 'from' that the flags ask for
    function automatic gzh_pkg::phase_t enter_from(input gzh_pkg::sect_t from,
                                                   input logic [7:0] flags);
        gzh_pkg::phase_t r;
        r = gzh_pkg::PH_PAYLOAD;
        if (from <= gzh_pkg::SEC_CRC && flags[gzh_pkg::FLG_FHCRC])
            r = gzh_pkg::PH_CRC_LO;
        if (from <= gzh_pkg::SEC_COMMENT && flags[gzh_pkg::FLG_FCOMMENT])
            r = gzh_pkg::PH_COMMENT;
        if (from <= gzh_pkg::SEC_NAME && flags[gzh_pkg::FLG_FNAME])
            r = gzh_pkg::PH_NAME;
        if (from == gzh_pkg::SEC_XLEN && flags[gzh_pkg::FLG_FEXTRA])
            r = gzh_pkg::PH_XLEN_LO;
        return r;
    endfunction

    // next state and result selection
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        magic_next = magic_reg;
        mtime_next = mtime_reg;
        xlen_next  = xlen_reg;
        crc_next   = crc_reg;
        emit_byte  = 1'b0;
        emit_done  = 1'b0;
        emit_bad   = 1'b0;
        byte_kind  = gzh_pkg::KIND_PAYLOAD;
        xlen_full  = 16'd0;

        // start of a new stream clears everything
        if (first_byte)
        begin
            phase_next = gzh_pkg::PH_FIXED;
            count_next = 16'd0;
            flag_next  = 8'd0;
            magic_next = 1'b1;
            mtime_next = 32'd0;
            xlen_next  = 16'd0;
            crc_next   = 16'd0;
        end

        count_inc = {1'b0, count_next} + 17'd1;

        case (phase_next)
            gzh_pkg::PH_FIXED:
            begin
                case (count_next)
                    16'd0: if (stream_byte != gzh_pkg::GZ_ID1) magic_next = 1'b0;
                    16'd1: if (stream_byte != gzh_pkg::GZ_ID2) magic_next = 1'b0;
                    16'd2: if (stream_byte != gzh_pkg::GZ_CM_DEFLATE) magic_next = 1'b0;
                    16'd3: flag_next = stream_byte;
                    16'd4: mtime_next[7:0]   = mtime_next[7:0]   | stream_byte;
                    16'd5: mtime_next[15:8]  = mtime_next[15:8]  | stream_byte;
                    16'd6: mtime_next[23:16] = mtime_next[23:16] | stream_byte;
                    16'd7: mtime_next[31:24] = mtime_next[31:24] | stream_byte;
                    default: ;
                endcase
                if (count_next >= 16'd9)
                begin
                    count_next = 16'd0;
                    if (!magic_next)
                    begin
                        phase_next = gzh_pkg::PH_ERROR;
                        emit_bad   = 1'b1;
                    end
                    else
                    begin
                        phase_next = enter_from(gzh_pkg::SEC_XLEN, flag_next);
                        emit_done  = (phase_next == gzh_pkg::PH_PAYLOAD);
                    end
                end
                else
                begin
                    count_next = count_inc[15:0];
                end
            end
            gzh_pkg::PH_XLEN_LO:
            begin
                xlen_next  = {8'd0, stream_byte};
                phase_next = gzh_pkg::PH_XLEN_HI;
            end
            gzh_pkg::PH_XLEN_HI:
            begin
                xlen_full  = {stream_byte, xlen_next[7:0]};
                xlen_next  = xlen_full;
                count_next = 16'd0;
                if (xlen_full == 16'd0)
                begin
                    phase_next = enter_from(gzh_pkg::SEC_NAME, flag_next);
                    emit_done  = (phase_next == gzh_pkg::PH_PAYLOAD);
                end
                else
                begin
                    phase_next = gzh_pkg::PH_EXTRA;
                end
            end
            gzh_pkg::PH_EXTRA:
            begin
                emit_byte = 1'b1;
                byte_kind = gzh_pkg::KIND_EXTRA;
                if (count_inc >= {1'b0, xlen_next})
                begin
                    count_next = 16'd0;
                    phase_next = enter_from(gzh_pkg::SEC_NAME, flag_next);
                    emit_done  = (phase_next == gzh_pkg::PH_PAYLOAD);
                end
                else
                begin
                    count_next = count_inc[15:0];
                end
            end
            gzh_pkg::PH_NAME, gzh_pkg::PH_COMMENT:
            begin
                emit_byte = 1'b1;
                byte_kind = (phase_next == gzh_pkg::PH_NAME) ? gzh_pkg::KIND_NAME
                                                             : gzh_pkg::KIND_COMMENT;
                if (stream_byte == 8'd0 || count_inc >= gzh_pkg::STR_LIMIT)
                begin
                    count_next = 16'd0;
                    phase_next = enter_from((phase_next == gzh_pkg::PH_NAME)
                                            ? gzh_pkg::SEC_COMMENT : gzh_pkg::SEC_CRC,
                                            flag_next);
                    emit_done  = (phase_next == gzh_pkg::PH_PAYLOAD);
                end
                else
                begin
                    count_next = count_inc[15:0];
                end
            end
            gzh_pkg::PH_CRC_LO:
            begin
                crc_next   = {8'd0, stream_byte};
                phase_next = gzh_pkg::PH_CRC_HI;
            end
            gzh_pkg::PH_CRC_HI:
            begin
                crc_next   = {stream_byte, crc_next[7:0]};
                phase_next = gzh_pkg::PH_PAYLOAD;
                emit_done  = 1'b1;
            end
            gzh_pkg::PH_PAYLOAD:
            begin
                emit_byte = 1'b1;
                byte_kind = gzh_pkg::KIND_PAYLOAD;
            end
            default: ;
        endcase
    end

    // result words: the byte itself, then header done or bad header
    always_comb
    begin
        byte_word              = '0;
        byte_word.kind         = byte_kind;
        byte_word.data_byte    = stream_byte;
        byte_word.last_of_run  = !(emit_done || emit_bad);

        end_word               = '0;
        end_word.kind          = emit_bad ? gzh_pkg::KIND_BAD : gzh_pkg::KIND_DONE;
        end_word.header_flags  = emit_done ? flag_next  : 8'd0;
        end_word.mod_time      = emit_done ? mtime_next : 32'd0;
        end_word.header_crc    = emit_done ? crc_next   : 16'd0;
        end_word.last_of_run   = 1'b1;

        push       = '0;
        push.word0 = emit_byte ? byte_word : end_word;
        push.word1 = end_word;
        if (accept)
            push.count = {1'b0, emit_byte} + {1'b0, (emit_done || emit_bad)};
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gzh_pkg::PH_FIXED;
            count_reg <= 16'd0;
            flag_reg  <= 8'd0;
            magic_reg <= 1'b1;
            mtime_reg <= 32'd0;
            xlen_reg  <= 16'd0;
            crc_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            magic_reg <= magic_next;
            mtime_reg <= mtime_next;
            xlen_reg  <= xlen_next;
            crc_reg   <= crc_next;
        end
    end

endmodule
`default_nettype wire

// File: design/gzh_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzh_out_queue
// Small result queue: takes up to two words a cycle, gives one word a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module gzh_out_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gzh_pkg::push_t push,
    output logic                room,
    gzh_out_if.source           result
);

    gzh_pkg::result_t                 slot_reg [gzh_pkg::QUEUE_DEPTH];
    logic [gzh_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [gzh_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [gzh_pkg::QUEUE_AW:0]       fill_reg, fill_next;
    logic [gzh_pkg::QUEUE_AW-1:0]     wr_ptr_second;
    logic                             pop;
    gzh_pkg::result_t                 head;

    // room for a two-word burst
    assign room = (fill_reg <= (gzh_pkg::QUEUE_AW+1)'(gzh_pkg::QUEUE_DEPTH - 2));
    assign pop  = result.valid && result.ready;
    assign wr_ptr_second = wr_ptr_reg + 1'b1;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count[gzh_pkg::QUEUE_AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(gzh_pkg::QUEUE_AW-1){1'b0}}, pop};
        fill_next   = fill_reg + {{(gzh_pkg::QUEUE_AW-1){1'b0}}, push.count}
                      - {{gzh_pkg::QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_ptr_reg] <= push.word0;
        if (push.count == 2'd2)
            slot_reg[wr_ptr_second] <= push.word1;
    end

    // head of queue onto the output channel
    assign head                = slot_reg[rd_ptr_reg];
    assign result.valid        = (fill_reg != '0);
    assign result.kind         = head.kind;
    assign result.data_byte    = head.data_byte;
    assign result.header_flags = head.header_flags;
    assign result.mod_time     = head.mod_time;
    assign result.header_crc   = head.header_crc;
    assign result.last_of_run  = head.last_of_run;

endmodule
`default_nettype wire

// File: design/gzip_member_header_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzip_member_header_parser_unit
// Parses a gzip member header byte by byte and streams out its sections.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and gives extra, name, comment and payload
// bytes as result words, plus one header done word (flags, mtime, header CRC)
// or one bad header word. A byte that ends a section can give two words; the
// four-word result queue absorbs them, so the block keeps taking one byte per
// cycle while the queue has room for two words and the output drains one word
// per cycle. Result words are registered in the queue before they reach the output.
module gzip_member_header_parser_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gzh_in_if.sink     stream,
    gzh_out_if.source  result
);

    gzh_pkg::push_t push;
    logic           room;
    logic           accept;

    assign stream.ready = room;
    assign accept       = stream.valid && room;

    // header state machine
    gzh_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream.stream_byte),
        .first_byte  (stream.first_byte),
        .push        (push)
    );

    // result queue
    gzh_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

`ifndef ASSERT_OFF
    // a two-word burst is a section byte followed by header done
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.word1.kind == gzh_pkg::KIND_DONE) &&
            (push.word0.kind == gzh_pkg::KIND_EXTRA || push.word0.kind == gzh_pkg::KIND_NAME
             || push.word0.kind == gzh_pkg::KIND_COMMENT))
        else $error("two-word burst with unexpected kinds");

    // only the final word of a burst is marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.word0.last_of_run && push.word1.last_of_run)
        else $error("last_of_run misplaced in burst");

    // input is held off only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !stream.ready |-> result.valid)
        else $error("input stalled with empty queue");

    // nothing is pushed without an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> push.count == 2'd0)
        else $error("result pushed without input");
`endif

endmodule
`default_nettype wire

// File: test/gzip_member_header_parser_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzip_member_header_parser_unit_test
// Self-checking bench for the gzip member header parser. A table of directed
// headers runs first: a start without a mark, every flag bit, extreme fields,
// empty strings, zero extra length, a restart into a bad method. Random
// members follow. Most are well formed with random flags, lengths and
// content. Some have a bad magic or method, some are cut short, and one
// name runs to the length limit. Every result word is checked against its
// table entry or a parse model kept in the bench. The sender idles in bursts,
// the receiver stalls on a changing pattern, and once it holds off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module gzip_member_header_parser_unit_test;

    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_CYCLES  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    // one stream byte, with the word it gives when that is known up front
    typedef struct packed {
        logic [7:0]       b;
        logic             first;
        logic             typed;
        gzh_pkg::result_t want;
    } row_t;

    localparam gzh_pkg::result_t NO_WORD = '0;

    localparam row_t DIRECTED_ROWS [27] = '{
        // header without a start mark, every flag bit set, extreme mtime
        '{8'h1f, 1'b0, 1'b0, NO_WORD},
        '{8'h8b, 1'b0, 1'b0, NO_WORD},
        '{8'h08, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        // zero extra length
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        // empty name and comment, only the terminating zero
        '{8'h00, 1'b0, 1'b1,
          '{gzh_pkg::KIND_NAME, 8'h00, 8'h00, 32'h0, 16'h0, 1'b1}},
        '{8'h00, 1'b0, 1'b1,
          '{gzh_pkg::KIND_COMMENT, 8'h00, 8'h00, 32'h0, 16'h0, 1'b1}},
        // header crc, then header done
        '{8'hff, 1'b0, 1'b0, NO_WORD},
        '{8'hff, 1'b0, 1'b1,
          '{gzh_pkg::KIND_DONE, 8'h00, 8'hff, 32'hffff_ffff, 16'hffff, 1'b1}},
        // payload
        '{8'hff, 1'b0, 1'b1,
          '{gzh_pkg::KIND_PAYLOAD, 8'hff, 8'h00, 32'h0, 16'h0, 1'b1}},
        // restart mid-stream into a header with a wrong method
        '{8'h1f, 1'b1, 1'b0, NO_WORD},
        '{8'h8b, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1,
          '{gzh_pkg::KIND_BAD, 8'h00, 8'h00, 32'h0, 16'h0, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gzh_in_if  stream_ch ();
    gzh_out_if result_ch ();

    gzip_member_header_parser_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parse model state
    gzh_pkg::phase_t parse_phase;
    logic [15:0]     field_count;
    logic [7:0]      hdr_flags;
    logic            magic_good;
    logic [31:0]     hdr_mtime;
    logic [15:0]     extra_len;
    logic [15:0]     hdr_crc;

    gzh_pkg::result_t byte_words[$];
    gzh_pkg::result_t pending_words[$];
    row_t             stream_rows[$];
    row_t             member_rows[$];

    int  sent;
    int  random_items;
    bit  prev_bad;
    int  words_checked;
    int  mismatches;
    int  done_seen;
    int  bad_seen;

    // ------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------
    function automatic gzh_pkg::result_t make_word(gzh_pkg::kind_t k, logic [7:0] d,
                                                   logic done);
        gzh_pkg::result_t w;
        w              = '0;
        w.kind         = k;
        w.data_byte    = d;
        w.header_flags = done ? hdr_flags : 8'h00;
        w.mod_time     = done ? hdr_mtime : 32'h0;
        w.header_crc   = done ? hdr_crc : 16'h0;
        return w;
    endfunction

    task automatic clear_parser();
        parse_phase = gzh_pkg::PH_FIXED;
        field_count = '0;
        hdr_flags   = '0;
        magic_good  = 1'b1;
        hdr_mtime   = '0;
        extra_len   = '0;
        hdr_crc     = '0;
    endtask

    // first section at or after from that the flags call for
    task automatic enter_section(gzh_pkg::sect_t from);
        field_count = '0;
        if (from <= gzh_pkg::SEC_XLEN && hdr_flags[gzh_pkg::FLG_FEXTRA])
            parse_phase = gzh_pkg::PH_XLEN_LO;
        else if (from <= gzh_pkg::SEC_NAME && hdr_flags[gzh_pkg::FLG_FNAME])
            parse_phase = gzh_pkg::PH_NAME;
        else if (from <= gzh_pkg::SEC_COMMENT && hdr_flags[gzh_pkg::FLG_FCOMMENT])
            parse_phase = gzh_pkg::PH_COMMENT;
        else if (from <= gzh_pkg::SEC_CRC && hdr_flags[gzh_pkg::FLG_FHCRC])
            parse_phase = gzh_pkg::PH_CRC_LO;
        else
        begin
            parse_phase = gzh_pkg::PH_PAYLOAD;
            byte_words.push_back(make_word(gzh_pkg::KIND_DONE, 8'h00, 1'b1));
        end
    endtask

    task automatic parse_byte(logic [7:0] b, logic first);
        logic [16:0]      next_count;
        gzh_pkg::kind_t   str_kind;
        gzh_pkg::result_t tail;
        if (first)
            clear_parser();
        next_count = {1'b0, field_count} + 17'd1;
        case (parse_phase)
            gzh_pkg::PH_FIXED:
            begin
                if (field_count == 16'd0 && b != gzh_pkg::GZ_ID1)
                    magic_good = 1'b0;
                if (field_count == 16'd1 && b != gzh_pkg::GZ_ID2)
                    magic_good = 1'b0;
                if (field_count == 16'd2 && b != gzh_pkg::GZ_CM_DEFLATE)
                    magic_good = 1'b0;
                if (field_count == 16'd3)
                    hdr_flags = b;
                if (field_count >= 16'd4 && field_count <= 16'd7)
                    hdr_mtime = hdr_mtime | (32'(b) << (8 * (int'(field_count) - 4)));
                if (field_count >= 16'd9)
                begin
                    field_count = '0;
                    if (!magic_good)
                    begin
                        parse_phase = gzh_pkg::PH_ERROR;
                        byte_words.push_back(make_word(gzh_pkg::KIND_BAD, 8'h00, 1'b0));
                    end
                    else
                        enter_section(gzh_pkg::SEC_XLEN);
                end
                else
                    field_count = next_count[15:0];
            end
            gzh_pkg::PH_XLEN_LO:
            begin
                extra_len   = {8'h00, b};
                parse_phase = gzh_pkg::PH_XLEN_HI;
            end
            gzh_pkg::PH_XLEN_HI:
            begin
                extra_len[15:8] = b;
                if (extra_len == 16'd0)
                    enter_section(gzh_pkg::SEC_NAME);
                else
                begin
                    parse_phase = gzh_pkg::PH_EXTRA;
                    field_count = '0;
                end
            end
            gzh_pkg::PH_EXTRA:
            begin
                byte_words.push_back(make_word(gzh_pkg::KIND_EXTRA, b, 1'b0));
                if (next_count >= {1'b0, extra_len})
                    enter_section(gzh_pkg::SEC_NAME);
                else
                    field_count = next_count[15:0];
            end
            gzh_pkg::PH_NAME, gzh_pkg::PH_COMMENT:
            begin
                str_kind = (parse_phase == gzh_pkg::PH_NAME) ? gzh_pkg::KIND_NAME
                                                             : gzh_pkg::KIND_COMMENT;
                byte_words.push_back(make_word(str_kind, b, 1'b0));
                if (b == 8'h00 || next_count >= gzh_pkg::STR_LIMIT)
                begin
                    if (str_kind == gzh_pkg::KIND_NAME)
                        enter_section(gzh_pkg::SEC_COMMENT);
                    else
                        enter_section(gzh_pkg::SEC_CRC);
                end
                else
                    field_count = next_count[15:0];
            end
            gzh_pkg::PH_CRC_LO:
            begin
                hdr_crc     = {8'h00, b};
                parse_phase = gzh_pkg::PH_CRC_HI;
            end
            gzh_pkg::PH_CRC_HI:
            begin
                hdr_crc[15:8] = b;
                parse_phase   = gzh_pkg::PH_PAYLOAD;
                byte_words.push_back(make_word(gzh_pkg::KIND_DONE, 8'h00, 1'b1));
            end
            gzh_pkg::PH_PAYLOAD:
                byte_words.push_back(make_word(gzh_pkg::KIND_PAYLOAD, b, 1'b0));
            default:
                ;
        endcase
        // mark the last word of this byte
        if (byte_words.size() > 0)
        begin
            tail = byte_words.pop_back();
            tail.last_of_run = 1'b1;
            byte_words.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // random member generation
    // ------------------------------------------------------------------
    function automatic row_t data_row(logic [7:0] b, logic first);
        row_t r;
        r       = '0;
        r.b     = b;
        r.first = first;
        return r;
    endfunction

    // name or comment: short zero-terminated, or cut at the length limit
    task automatic push_string(bit stretch);
        int len;
        len = stretch ? gzh_pkg::MAX_STRING : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
            member_rows.push_back(data_row(8'($urandom_range(1, 255)), 1'b0));
        if (!stretch)
            member_rows.push_back(data_row(8'h00, 1'b0));
    endtask

    task automatic add_member(bit stretch);
        logic [7:0]  flg;
        logic [31:0] mt;
        int          bad_field;
        int          len;
        int          pick;
        int          keep;
        logic        start_first;
        member_rows.delete();
        bad_field = stretch ? 3 : $urandom_range(0, 35);
        flg = 8'($urandom);
        if (stretch)
            flg[gzh_pkg::FLG_FNAME] = 1'b1;
        mt = $urandom;
        start_first = prev_bad || ($urandom_range(0, 15) != 0);

        // fixed header, with one id or method byte spoiled now and then
        member_rows.push_back(data_row(
            bad_field == 0 ? gzh_pkg::GZ_ID1 ^ 8'($urandom_range(1, 255))
                           : gzh_pkg::GZ_ID1,
            start_first));
        member_rows.push_back(data_row(
            bad_field == 1 ? gzh_pkg::GZ_ID2 ^ 8'($urandom_range(1, 255))
                           : gzh_pkg::GZ_ID2,
            1'b0));
        member_rows.push_back(data_row(
            bad_field == 2 ? gzh_pkg::GZ_CM_DEFLATE ^ 8'($urandom_range(1, 255))
                           : gzh_pkg::GZ_CM_DEFLATE,
            1'b0));
        member_rows.push_back(data_row(flg, 1'b0));
        for (int i = 0; i < 4; i++)
            member_rows.push_back(data_row(mt[8 * i +: 8], 1'b0));
        member_rows.push_back(data_row(8'($urandom), 1'b0));
        member_rows.push_back(data_row(8'($urandom), 1'b0));

        if (bad_field < 3)
        begin
            foreach (member_rows[i])
                stream_rows.push_back(member_rows[i]);
            random_items += member_rows.size();
            // a few ignored bytes after the bad header
            pick = $urandom_range(0, 2);
            for (int i = 0; i < pick; i++)
                stream_rows.push_back(data_row(8'($urandom), 1'b0));
            prev_bad = 1'b1;
            return;
        end

        // extra field: mostly short, rarely empty or long
        if (flg[gzh_pkg::FLG_FEXTRA])
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                len = 0;
            else if (pick == 1)
                len = $urandom_range(200, 700);
            else
                len = $urandom_range(1, 12);
            member_rows.push_back(data_row(len[7:0], 1'b0));
            member_rows.push_back(data_row(len[15:8], 1'b0));
            for (int i = 0; i < len; i++)
                member_rows.push_back(data_row(8'($urandom), 1'b0));
        end
        if (flg[gzh_pkg::FLG_FNAME])
            push_string(stretch);
        if (flg[gzh_pkg::FLG_FCOMMENT])
            push_string(1'b0);
        if (flg[gzh_pkg::FLG_FHCRC])
        begin
            member_rows.push_back(data_row(8'($urandom), 1'b0));
            member_rows.push_back(data_row(8'($urandom), 1'b0));
        end
        len = $urandom_range(0, 24);
        for (int i = 0; i < len; i++)
            member_rows.push_back(data_row(8'($urandom), 1'b0));

        // broken member: cut short, the next start mark restarts the parse
        if (!stretch && $urandom_range(0, 9) == 0)
        begin
            keep = $urandom_range(1, member_rows.size() - 1);
            while (member_rows.size() > keep)
                void'(member_rows.pop_back());
        end

        foreach (member_rows[i])
            stream_rows.push_back(member_rows[i]);
        random_items += member_rows.size();
        prev_bad = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // byte sender: bursts with random gaps, model runs per accepted byte, not word
    // ------------------------------------------------------------------
    initial
    begin : byte_side
        int burst;
        int gap;
        burst = $urandom_range(1, 40);
        gap   = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (stream_ch.valid && stream_ch.ready)
            begin
                byte_words.delete();
                parse_byte(stream_rows[sent].b, stream_rows[sent].first);
                if (stream_rows[sent].typed)
                    pending_words.push_back(stream_rows[sent].want);
                else
                    foreach (byte_words[k])
                        pending_words.push_back(byte_words[k]);
                sent++;
            end
            if (stream_ch.valid && !stream_ch.ready)
                ;
            else if (sent < stream_rows.size() && gap == 0)
            begin
                stream_ch.valid       <= 1'b1;
                stream_ch.stream_byte <= stream_rows[sent].b;
                stream_ch.first_byte  <= stream_rows[sent].first;
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 40);
                    gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                stream_ch.valid <= 1'b0;
                if (gap > 0)
                    gap--;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: checks each word, stalls on a changing pattern
    // ------------------------------------------------------------------
    initial
    begin : result_side
        gzh_pkg::result_t got;
        gzh_pkg::result_t want;
        int               cyc;
        int               mode;
        int               hold;
        logic [15:0]      pattern;
        logic             next_ready;
        bit               pressed;
        cyc     = 0;
        mode    = 0;
        hold    = 0;
        pattern = 16'hffff;
        pressed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{gzh_pkg::kind_t'(result_ch.kind), result_ch.data_byte,
                        result_ch.header_flags, result_ch.mod_time,
                        result_ch.header_crc, result_ch.last_of_run};
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("word %0d arrived with nothing expected: kind %0d data %02h",
                                 words_checked, got.kind, got.data_byte);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.header_flags !== want.header_flags ||
                        got.mod_time !== want.mod_time ||
                        got.header_crc !== want.header_crc ||
                        got.last_of_run !== want.last_of_run)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"word %0d: expected kind %0d data %02h flags %02h ",
                                      "mtime %08h crc %04h last %0d, got kind %0d data %02h ",
                                      "flags %02h mtime %08h crc %04h last %0d"},
                                     words_checked, want.kind, want.data_byte,
                                     want.header_flags, want.mod_time, want.header_crc,
                                     want.last_of_run, got.kind, got.data_byte,
                                     got.header_flags, got.mod_time, got.header_crc,
                                     got.last_of_run);
                    end
                end
                if (got.kind === gzh_pkg::KIND_DONE)
                    done_seen++;
                if (got.kind === gzh_pkg::KIND_BAD)
                    bad_seen++;
                words_checked++;
            end

            // new stall pattern and stall mode, drawn at random
            cyc++;
            if (cyc % 48 == 0)
            begin
                pattern = 16'($urandom);
                mode    = $urandom_range(0, 3);
            end
            // one long hold-off so the input side backs up
            if (!pressed && words_checked >= 400)
            begin
                pressed = 1'b1;
                hold    = 300;
            end
            if (hold > 0)
            begin
                hold--;
                next_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = pattern[cyc % 16];
                    2:       next_ready = pattern[cyc % 16] | pattern[(cyc + 5) % 16];
                    default: next_ready = ($urandom_range(0, 3) != 0);
                endcase
            end
            result_ch.ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no word moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("no word moved for %0d cycles, %0d words still expected",
                 STALL_LIMIT, pending_words.size());
        $display("gzip_member_header_parser_unit_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        int m;
        stream_ch.valid       <= 1'b0;
        stream_ch.stream_byte <= 8'h00;
        stream_ch.first_byte  <= 1'b0;
        result_ch.ready       <= 1'b0;
        sent          = 0;
        random_items  = 0;
        prev_bad      = 1'b1;
        words_checked = 0;
        mismatches    = 0;
        done_seen     = 0;
        bad_seen      = 0;
        clear_parser();

        // directed table, then random members; one member runs its name to the limit
        foreach (DIRECTED_ROWS[i])
            stream_rows.push_back(DIRECTED_ROWS[i]);
        m = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            add_member(m == 6);
            m++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all bytes in, all words out, then a short quiet tail
        while (sent < stream_rows.size())
            @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d stream bytes in %0d random members after %0d directed bytes",
                 sent, m, $size(DIRECTED_ROWS));
        $display("checked %0d result words: %0d headers done, %0d bad headers, %0d mismatches",
                 words_checked, done_seen, bad_seen, mismatches);
        if (mismatches == 0)
            $display("gzip_member_header_parser_unit_test: done, clean");
        else
            $display("gzip_member_header_parser_unit_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
